>>> src/tgargba_pkg.sv
// ----------------------------------------------------------------------------
// tgargba_pkg
// Types and constants for the TGA to premultiplied RGBA decoder.
// ----------------------------------------------------------------------------
package tgargba_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PHASE_HEADER = 2'd0,
        PHASE_PIXELS = 2'd1,
        PHASE_SKIP   = 2'd2
    } phase_t;

    // Result kinds (carried on tuser)
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    // Status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_SHORT     = 3'd1;
    localparam logic [2:0] STATUS_BAD_TYPE  = 3'd2;
    localparam logic [2:0] STATUS_BAD_DEPTH = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

    // Header byte offsets
    localparam logic [4:0] HDR_TYPE     = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_DESC     = 5'd17;

    // Only uncompressed truecolor files are accepted
    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;

    // Minimum bytes per pixel, and the count that carries alpha
    localparam logic [3:0] MIN_BYTES_PER_PIXEL = 4'd3;
    localparam logic [3:0] ALPHA_BYTES_PER_PIXEL = 4'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

endpackage

>>> src/tga_to_premultiplied_rgba_top.sv
// ----------------------------------------------------------------------------
// tga_to_premultiplied_rgba_top
// Streaming decoder of uncompressed truecolor TGA files to premultiplied RGBA.
// ----------------------------------------------------------------------------
// The block takes one file byte per item and accepts a byte in every cycle
// while the result side keeps up. Each byte gives at most one result. That
// result is registered: the accepted byte is loaded into the input register,
// and the result it gives is loaded into the result register when the byte is
// processed, which waits while a result there has not been taken. The
// 18-byte header is checked when its last byte arrives and one header result
// reports the status and, when ok, the width and height. Pixel bytes (B,G,R
// or B,G,R,A,...) then give one RGBA result per pixel, premultiplied when the
// file has four bytes per pixel, with a row-major destination index that is
// flipped vertically unless descriptor bit 5 is set. A file that ends inside
// the pixel data gives a truncated status. The tlast byte always returns the
// decoder to the header. Image ID and color-map bytes are not skipped.
// ----------------------------------------------------------------------------
module tga_to_premultiplied_rgba_top
    import tgargba_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input item
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // end_of_file
    // result item
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [2:0] status, [10:3] red, [18:11] green,
                                    // [26:19] blue, [34:27] alpha,
                                    // [64:35] pixel_index, [80:65] image_width,
                                    // [96:81] image_height, [103:97] zero
    output logic         m_tlast,   // image_done
    output logic         m_tuser    // result_kind
);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_eof_reg;

    phase_t       phase_reg, phase_next;
    logic [4:0]   header_count_reg, header_count_next;
    logic [7:0]   image_type_reg, image_type_next;
    logic [7:0]   depth_bits_reg, depth_bits_next;
    logic [15:0]  width_value_reg, width_value_next;
    logic [15:0]  height_value_reg, height_value_next;
    logic         top_down_reg, top_down_next;
    logic [4:0]   byte_in_pixel_reg, byte_in_pixel_next;
    logic [7:0]   held_reg [3];
    logic [7:0]   held_next [3];
    logic [14:0]  column_reg, column_next;
    logic [14:0]  row_reg, row_next;
    logic [29:0]  row_base_reg, row_base_next;
    logic [29:0]  span_reg;

    logic         out_valid_reg;
    logic         out_kind_reg;
    logic [2:0]   out_status_reg;
    logic [7:0]   out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic [29:0]  out_index_reg;
    logic [15:0]  out_width_reg, out_height_reg;
    logic         out_done_reg;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // ------------------------------------------------------------------------
    // Shared decode
    // ------------------------------------------------------------------------
    logic [3:0]  bytes_per_pixel;
    logic [14:0] width15, height15;
    logic        dims_positive;
    logic        header_end;
    logic        type_ok, depth_ok;
    logic        pixel_complete;
    logic        last_pixel;
    logic        row_end;

    assign bytes_per_pixel = depth_bits_reg[7] ? 4'd0 : depth_bits_reg[6:3];
    assign width15         = width_value_reg[14:0];
    assign height15        = height_value_reg[14:0];
    assign dims_positive   = !width_value_reg[15] && (width15 != 15'd0)
                          && !height_value_reg[15] && (height15 != 15'd0);
    assign header_end      = (header_count_reg >= HDR_DESC);
    assign type_ok         = (image_type_reg == TYPE_TRUECOLOR);
    assign depth_ok        = (bytes_per_pixel >= MIN_BYTES_PER_PIXEL);
    assign pixel_complete  = ({1'b0, byte_in_pixel_reg} + 6'd1) >= {2'b00, bytes_per_pixel};
    assign row_end         = ({1'b0, column_reg} + 16'd1) >= {1'b0, width15};
    assign last_pixel      = row_end && (({1'b0, row_reg} + 16'd1) >= {1'b0, height15});

    // ------------------------------------------------------------------------
    // Premultiply: floor(c * a / 255)
    // ------------------------------------------------------------------------
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    logic [15:0] prod_red, prod_green, prod_blue;

    assign prod_red   = held_reg[2] * in_byte_reg;
    assign prod_green = held_reg[1] * in_byte_reg;
    assign prod_blue  = held_reg[0] * in_byte_reg;

    // Start of the last row, used as the first row of a bottom-up image
    always_ff @(posedge aclk) begin
        span_reg <= {15'd0, height15 - 15'd1} * {15'd0, width15};
    end

    // ------------------------------------------------------------------------
    // Next phase
    // ------------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PHASE_PIXELS: begin
                if (in_eof_reg) begin
                    phase_next = PHASE_HEADER;
                end else if (pixel_complete && last_pixel) begin
                    phase_next = PHASE_SKIP;
                end
            end
            PHASE_SKIP: begin
                if (in_eof_reg) begin
                    phase_next = PHASE_HEADER;
                end
            end
            default: begin
                if (in_eof_reg) begin
                    phase_next = PHASE_HEADER;
                end else if (header_end) begin
                    if (type_ok && depth_ok && dims_positive) begin
                        phase_next = PHASE_PIXELS;
                    end else begin
                        phase_next = PHASE_SKIP;
                    end
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath and result
    // ------------------------------------------------------------------------
    logic        res_valid;
    logic        res_kind;
    logic [2:0]  res_status;
    logic [7:0]  res_red, res_green, res_blue, res_alpha;
    logic [29:0] res_index;
    logic [15:0] res_width, res_height;
    logic        res_done;

    always_comb begin
        header_count_next  = header_count_reg;
        image_type_next    = image_type_reg;
        depth_bits_next    = depth_bits_reg;
        width_value_next   = width_value_reg;
        height_value_next  = height_value_reg;
        top_down_next      = top_down_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        held_next          = held_reg;
        column_next        = column_reg;
        row_next           = row_reg;
        row_base_next      = row_base_reg;

        res_valid  = 1'b0;
        res_kind   = KIND_HEADER;
        res_status = STATUS_OK;
        res_red    = 8'd0;
        res_green  = 8'd0;
        res_blue   = 8'd0;
        res_alpha  = 8'd0;
        res_index  = 30'd0;
        res_width  = 16'd0;
        res_height = 16'd0;
        res_done   = 1'b0;

        case (phase_reg)
            PHASE_PIXELS: begin
                if (byte_in_pixel_reg < 5'd3) begin
                    held_next[byte_in_pixel_reg[1:0]] = in_byte_reg;
                end
                if (!pixel_complete) begin
                    // collect another byte of this pixel
                    byte_in_pixel_next = byte_in_pixel_reg + 5'd1;
                    if (in_eof_reg) begin
                        header_count_next = 5'd0;
                        res_valid  = 1'b1;
                        res_status = STATUS_TRUNCATED;
                        res_done   = 1'b1;
                    end
                end else begin
                    byte_in_pixel_next = 5'd0;
                    if (in_eof_reg && !last_pixel) begin
                        header_count_next = 5'd0;
                        res_valid  = 1'b1;
                        res_status = STATUS_TRUNCATED;
                        res_done   = 1'b1;
                    end else begin
                        // emit the pixel
                        res_valid = 1'b1;
                        res_kind  = KIND_PIXEL;
                        res_index = row_base_reg + {15'd0, column_reg};
                        res_done  = last_pixel;
                        if (bytes_per_pixel == ALPHA_BYTES_PER_PIXEL) begin
                            res_red   = div255(prod_red);
                            res_green = div255(prod_green);
                            res_blue  = div255(prod_blue);
                            res_alpha = in_byte_reg;
                        end else begin
                            // red may arrive with this very byte
                            res_red   = held_next[2];
                            res_green = held_next[1];
                            res_blue  = held_next[0];
                            res_alpha = ALPHA_OPAQUE;
                        end
                        // advance the raster position
                        if (last_pixel) begin
                            column_next = 15'd0;
                            row_next    = 15'd0;
                            if (in_eof_reg) begin
                                header_count_next = 5'd0;
                            end
                        end else if (row_end) begin
                            column_next = 15'd0;
                            row_next    = row_reg + 15'd1;
                            if (top_down_reg) begin
                                row_base_next = row_base_reg + {15'd0, width15};
                            end else begin
                                row_base_next = row_base_reg - {15'd0, width15};
                            end
                        end else begin
                            column_next = column_reg + 15'd1;
                        end
                    end
                end
            end
            PHASE_SKIP: begin
                if (in_eof_reg) begin
                    header_count_next = 5'd0;
                end
            end
            default: begin
                // capture header fields
                case (header_count_reg)
                    HDR_TYPE:      image_type_next = in_byte_reg;
                    HDR_WIDTH_LO:  width_value_next[7:0] = in_byte_reg;
                    HDR_WIDTH_HI:  width_value_next[15:8] = in_byte_reg;
                    HDR_HEIGHT_LO: height_value_next[7:0] = in_byte_reg;
                    HDR_HEIGHT_HI: height_value_next[15:8] = in_byte_reg;
                    HDR_DEPTH:     depth_bits_next = in_byte_reg;
                    HDR_DESC:      top_down_next = in_byte_reg[5];
                    default:       ;
                endcase
                if (in_eof_reg) begin
                    header_count_next = 5'd0;
                    res_valid  = 1'b1;
                    res_status = STATUS_SHORT;
                    res_done   = 1'b1;
                end else if (!header_end) begin
                    header_count_next = header_count_reg + 5'd1;
                end else begin
                    // check the completed header
                    header_count_next = 5'd0;
                    res_valid = 1'b1;
                    res_done  = 1'b1;
                    if (!type_ok) begin
                        res_status = STATUS_BAD_TYPE;
                    end else if (!depth_ok) begin
                        res_status = STATUS_BAD_DEPTH;
                    end else begin
                        res_status         = STATUS_OK;
                        res_width          = width_value_reg;
                        res_height         = height_value_reg;
                        res_done           = !dims_positive;
                        byte_in_pixel_next = 5'd0;
                        column_next        = 15'd0;
                        row_next           = 15'd0;
                        row_base_next      = in_byte_reg[5] ? 30'd0 : span_reg;
                    end
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
    end

    // ------------------------------------------------------------------------
    // Decoder state: advance once per processed byte
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PHASE_HEADER;
            header_count_reg  <= 5'd0;
            image_type_reg    <= 8'd0;
            depth_bits_reg    <= 8'd0;
            width_value_reg   <= 16'd0;
            height_value_reg  <= 16'd0;
            top_down_reg      <= 1'b0;
            byte_in_pixel_reg <= 5'd0;
            held_reg          <= '{8'd0, 8'd0, 8'd0};
            column_reg        <= 15'd0;
            row_reg           <= 15'd0;
            row_base_reg      <= 30'd0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            image_type_reg    <= image_type_next;
            depth_bits_reg    <= depth_bits_next;
            width_value_reg   <= width_value_next;
            height_value_reg  <= height_value_next;
            top_down_reg      <= top_down_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            held_reg          <= held_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            row_base_reg      <= row_base_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result register: hold until taken
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_kind_reg   <= res_kind;
            out_status_reg <= res_status;
            out_red_reg    <= res_red;
            out_green_reg  <= res_green;
            out_blue_reg   <= res_blue;
            out_alpha_reg  <= res_alpha;
            out_index_reg  <= res_index;
            out_width_reg  <= res_width;
            out_height_reg <= res_height;
            out_done_reg   <= res_done;
        end
    end

    // Pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {7'd0, out_height_reg, out_width_reg, out_index_reg,
                       out_alpha_reg, out_blue_reg, out_green_reg, out_red_reg,
                       out_status_reg};

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TGA to premultiplied RGBA decoder.
// A scoreboard tracks header and pixel decoding byte by byte and predicts
// every status and pixel item; directed files hit the header checks, empty
// and truncated images and the alpha extremes, then random files (mostly
// well formed, some cut short or malformed) run with random input gaps and
// back-pressure on the result channel.
// ----------------------------------------------------------------------------
import tgargba_pkg::*;

typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [29:0] index;
    logic [15:0] width;
    logic [15:0] height;
    logic        done;
} rgba_result_t;

class rgba_scoreboard;
    phase_t         phase;
    logic [4:0]     hdr_pos;
    logic [7:0]     img_type;
    logic [7:0]     depth;
    logic [15:0]    wid;
    logic [15:0]    hgt;
    logic           top_down;
    logic [4:0]     pix_byte;
    logic [7:0]     chan [3];
    logic [14:0]    col;
    logic [14:0]    row;
    rgba_result_t   expected_q [$];
    int             errors;

    function new();
        phase    = PHASE_HEADER;
        hdr_pos  = '0;
        img_type = '0;
        depth    = '0;
        wid      = '0;
        hgt      = '0;
        top_down = 1'b0;
        pix_byte = '0;
        chan     = '{default: 8'd0};
        col      = '0;
        row      = '0;
        errors   = 0;
    endfunction

    // Negative depth bytes give zero bytes per pixel
    function int bytes_per_pixel();
        return depth[7] ? 0 : int'(depth[6:0]) / 8;
    endfunction

    function void restart();
        phase   = PHASE_HEADER;
        hdr_pos = '0;
    endfunction

    function void push_status(logic [2:0] st, bit with_size, bit done);
        rgba_result_t e;
        e = '0;
        e.kind   = KIND_HEADER;
        e.status = st;
        if (with_size) begin
            e.width  = wid;
            e.height = hgt;
        end
        e.done = done;
        expected_q.push_back(e);
    endfunction

    // Advance the decoder by one accepted byte and queue what it produces
    function void note_byte(logic [7:0] b, bit eof);
        int           mode;
        int           w;
        int           h;
        int           a;
        int           dest_row;
        bit           last;
        logic [63:0]  idx;
        rgba_result_t e;

        if (phase == PHASE_PIXELS) begin
            mode = bytes_per_pixel();
            w = int'(wid[14:0]);
            h = int'(hgt[14:0]);
            if (pix_byte < 5'd3)
                chan[pix_byte[1:0]] = b;
            if (int'(pix_byte) + 1 < mode) begin
                pix_byte++;
                if (eof) begin
                    restart();
                    push_status(STATUS_TRUNCATED, 1'b0, 1'b1);
                end
            end else begin
                pix_byte = '0;
                last = (int'(col) + 1 >= w) && (int'(row) + 1 >= h);
                if (eof && !last) begin
                    // the pixel this byte completes is dropped
                    restart();
                    push_status(STATUS_TRUNCATED, 1'b0, 1'b1);
                end else begin
                    // opaque pixels scale by 255/255, which leaves them unchanged
                    a = (mode == int'(ALPHA_BYTES_PER_PIXEL)) ? int'(b) : int'(ALPHA_OPAQUE);
                    dest_row = top_down ? int'(row) : h - 1 - int'(row);
                    idx = 64'(dest_row) * 64'(w) + 64'(col);
                    e = '0;
                    e.kind   = KIND_PIXEL;
                    e.status = STATUS_OK;
                    e.red    = 8'(int'(chan[2]) * a / 255);
                    e.green  = 8'(int'(chan[1]) * a / 255);
                    e.blue   = 8'(int'(chan[0]) * a / 255);
                    e.alpha  = 8'(a);
                    e.index  = idx[29:0];
                    e.done   = last;
                    expected_q.push_back(e);
                    if (last) begin
                        col = '0;
                        row = '0;
                        if (eof)
                            restart();
                        else
                            phase = PHASE_SKIP;
                    end else if (int'(col) + 1 >= w) begin
                        col = '0;
                        row++;
                    end else begin
                        col++;
                    end
                end
            end
        end else if (phase == PHASE_SKIP) begin
            if (eof)
                restart();
        end else begin
            case (hdr_pos)
                HDR_TYPE:      img_type = b;
                HDR_WIDTH_LO:  wid[7:0] = b;
                HDR_WIDTH_HI:  wid[15:8] = b;
                HDR_HEIGHT_LO: hgt[7:0] = b;
                HDR_HEIGHT_HI: hgt[15:8] = b;
                HDR_DEPTH:     depth = b;
                HDR_DESC:      top_down = b[5];
                default: ;
            endcase
            if (eof) begin
                restart();
                push_status(STATUS_SHORT, 1'b0, 1'b1);
            end else if (hdr_pos < HDR_DESC) begin
                hdr_pos++;
            end else begin
                hdr_pos = '0;
                if (img_type != TYPE_TRUECOLOR) begin
                    phase = PHASE_SKIP;
                    push_status(STATUS_BAD_TYPE, 1'b0, 1'b1);
                end else if (bytes_per_pixel() < int'(MIN_BYTES_PER_PIXEL)) begin
                    phase = PHASE_SKIP;
                    push_status(STATUS_BAD_DEPTH, 1'b0, 1'b1);
                end else begin
                    pix_byte = '0;
                    col = '0;
                    row = '0;
                    if ($signed(wid) <= 0 || $signed(hgt) <= 0) begin
                        phase = PHASE_SKIP;
                        push_status(STATUS_OK, 1'b1, 1'b1);
                    end else begin
                        phase = PHASE_PIXELS;
                        push_status(STATUS_OK, 1'b1, 1'b0);
                    end
                end
            end
        end
    endfunction

    function string describe(rgba_result_t r);
        return $sformatf("kind=%0d status=%0d rgba=%0d/%0d/%0d/%0d index=%0d size=%0dx%0d done=%0d",
                         r.kind, r.status, r.red, r.green, r.blue, r.alpha, r.index,
                         $signed(r.width), $signed(r.height), r.done);
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // Compare one accepted result item with the oldest prediction
    function void check_result(logic [103:0] data, logic last, logic user);
        rgba_result_t got;
        rgba_result_t want;

        got.kind   = user;
        got.status = data[2:0];
        got.red    = data[10:3];
        got.green  = data[18:11];
        got.blue   = data[26:19];
        got.alpha  = data[34:27];
        got.index  = data[64:35];
        got.width  = data[80:65];
        got.height = data[96:81];
        got.done   = last;
        if (expected_q.size() == 0) begin
            note_error({"result with nothing expected: ", describe(got)});
            return;
        end
        want = expected_q.pop_front();
        if (got !== want || data[103:97] !== 7'd0)
            note_error({"mismatch: expected ", describe(want), " got ", describe(got),
                        $sformatf(" pad=%0h", data[103:97])});
    endfunction
endclass

module tb;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int BYTE_GOAL     = 2000;
    localparam int CALM_AFTER    = 1750;
    localparam int LONG_HOLD     = 300;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'd0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    rgba_scoreboard sb = new();
    logic [7:0]     tga_file [$];
    int             bytes_sent   = 0;
    int             results_seen = 0;
    bit             calm         = 1'b0;

    tga_to_premultiplied_rgba_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Build an 18-byte header with random filler in the unused fields
    function automatic void start_file(logic [7:0] kind, logic [15:0] w, logic [15:0] h,
                                       logic [7:0] depth, logic [7:0] desc);
        tga_file.delete();
        for (int i = 0; i < 18; i++)
            tga_file.push_back(8'($urandom));
        tga_file[HDR_TYPE]      = kind;
        tga_file[HDR_WIDTH_LO]  = w[7:0];
        tga_file[HDR_WIDTH_HI]  = w[15:8];
        tga_file[HDR_HEIGHT_LO] = h[7:0];
        tga_file[HDR_HEIGHT_HI] = h[15:8];
        tga_file[HDR_DEPTH]     = depth;
        tga_file[HDR_DESC]      = desc;
    endfunction

    function automatic void add_noise(int n);
        for (int i = 0; i < n; i++)
            tga_file.push_back(8'($urandom));
    endfunction

    // Stream the current file, tlast on its final byte, with random gaps
    task automatic send_file();
        int gap;
        foreach (tga_file[i]) begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= tga_file[i];
            s_tlast  <= (i == tga_file.size() - 1);
            do @(posedge aclk); while (!s_tready);
            sb.note_byte(tga_file[i], i == tga_file.size() - 1);
            bytes_sent++;
        end
    endtask

    // Result side: check items, stall in random bursts, hold off long twice
    initial begin : result_sink
        int hold;
        int pressed_at;
        hold = 0;
        pressed_at = -1;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tlast, m_tuser);
                results_seen++;
            end
            if (hold > 0)
                hold--;
            else if ((results_seen == 40 || results_seen == 600) && pressed_at != results_seen) begin
                hold = LONG_HOLD;
                pressed_at = results_seen;
            end else if (!calm && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 8);
            m_tready <= (hold == 0);
        end
    end

    // End the run when nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[tga_to_premultiplied_rgba_top] ERROR");
        $finish;
    end

    initial begin : stimulus
        int         w;
        int         h;
        int         bpp;
        int         pick;
        int         total;
        int         keep;
        logic [7:0] depth;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // file of a single byte, and one that stops right at header end
        tga_file.delete();
        add_noise(1);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd24, 8'd0);
        send_file();

        // rejected headers: wrong type, too few bits, negative depth byte
        start_file(8'd10, 16'd2, 16'd2, 8'd24, 8'd0);
        add_noise(5);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd16, 8'd0);
        add_noise(3);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'd2, 16'd2, 8'hF8, 8'd0);
        add_noise(2);
        send_file();

        // empty images: zero width, negative height
        start_file(TYPE_TRUECOLOR, 16'd0, 16'd3, 8'd24, 8'd0);
        add_noise(2);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'd3, 16'h8000, 8'd32, 8'hFF);
        add_noise(1);
        send_file();

        // bottom-up BGR image ending exactly on its last pixel
        start_file(TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd24, 8'd0);
        add_noise(12);
        send_file();

        // top-down BGRA image with alpha extremes, then trailing bytes
        start_file(TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd32, 8'h20);
        tga_file = {tga_file, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h00,
                    8'hC8, 8'h64, 8'h32, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF};
        add_noise(3);
        send_file();

        // extra bytes per pixel are skipped
        start_file(TYPE_TRUECOLOR, 16'd3, 16'd1, 8'd40, 8'hDF);
        add_noise(17);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd127, 8'd0);
        add_noise(15);
        send_file();

        // files cut inside a pixel and on a pixel boundary
        start_file(TYPE_TRUECOLOR, 16'd3, 16'd2, 8'd24, 8'd0);
        add_noise(7);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'd3, 16'd2, 8'd24, 8'd0);
        add_noise(9);
        send_file();

        // largest dimensions, cut after a few pixels
        start_file(TYPE_TRUECOLOR, 16'h7FFF, 16'h7FFF, 8'd24, 8'd0);
        add_noise(10);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'd1, 16'h7FFF, 8'd32, 8'd0);
        add_noise(9);
        send_file();
        start_file(TYPE_TRUECOLOR, 16'h7FFF, 16'd2, 8'd24, 8'h20);
        add_noise(8);
        send_file();

        // random files: mostly well formed, some cut short or malformed
        while (bytes_sent < BYTE_GOAL) begin
            if (bytes_sent >= CALM_AFTER)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 5);
            h = $urandom_range(1, 5);
            keep = $urandom_range(0, 9);
            depth = (keep < 5) ? 8'd24 : (keep < 9) ? 8'd32 : 8'($urandom_range(24, 127));
            bpp = int'(depth) / 8;
            total = w * h * bpp;
            if (pick < 70) begin
                start_file(TYPE_TRUECOLOR, 16'(w), 16'(h), depth, 8'($urandom));
                add_noise(total + ($urandom_range(0, 1) ? $urandom_range(1, 4) : 0));
            end else if (pick < 82) begin
                start_file(TYPE_TRUECOLOR, 16'(w), 16'(h), depth, 8'($urandom));
                add_noise($urandom_range(1, total - 1));
            end else if (pick < 90) begin
                start_file(TYPE_TRUECOLOR, 16'(w), 16'(h), depth, 8'($urandom));
                keep = $urandom_range(1, 18);
                while (tga_file.size() > keep)
                    void'(tga_file.pop_back());
            end else begin
                start_file($urandom_range(0, 1) ? TYPE_TRUECOLOR : 8'($urandom),
                           16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
                add_noise($urandom_range(0, 6));
            end
            send_file();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain outstanding results, then allow stray items to show up
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("[tga_to_premultiplied_rgba_top] OK");
        else
            $display("[tga_to_premultiplied_rgba_top] ERROR");
        $finish;
    end

endmodule
